### hw/rtl/dcv_pkg.sv
// Shared types, codes and constants of the dual-channel command voter.
package dcv_pkg;

  // Record layout
  localparam int REC_LEN             = 13;
  localparam int ANALOG_CHANNELS_DEF = 8;
  localparam logic [3:0] SLOT_SAFETY = 4'd8;
  localparam logic [3:0] SLOT_DIR_HI = 4'd9;
  localparam logic [3:0] SLOT_DIR_LO = 4'd10;
  localparam logic [3:0] SLOT_DIG1   = 4'd11;
  localparam logic [3:0] SLOT_DIG2   = 4'd12;
  localparam logic [3:0] SLOT_LIMIT  = 4'd13;

  // Telegram layout
  localparam logic [3:0] TLG_SAFETY   = 4'd0;
  localparam logic [3:0] TLG_LAST_DIG = 4'd4;
  localparam logic [3:0] TLG_LAST     = 4'd12;

  // Operation codes
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_EVAL   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [2:0] REG_TOLERANCE = 3'd0;
  localparam logic [2:0] REG_CONNECT   = 3'd1;
  localparam logic [2:0] REG_TAP_LOW   = 3'd2;
  localparam logic [2:0] REG_TAP_HIGH  = 3'd3;
  localparam logic [2:0] REG_TAP_NOM   = 3'd4;

  // Configuration reset values
  localparam logic [7:0] TOLERANCE_RST = 8'd20;
  localparam logic [7:0] CONNECT_RST   = 8'd22;
  localparam logic [7:0] TAP_LOW_RST   = 8'd122;
  localparam logic [7:0] TAP_HIGH_RST  = 8'd132;
  localparam logic [7:0] TAP_NOM_RST   = 8'd127;

  // Command class codes
  localparam logic [2:0] CLS_OFF     = 3'd0;
  localparam logic [2:0] CLS_SAFETY  = 3'd1;
  localparam logic [2:0] CLS_DIG_LOW = 3'd2;
  localparam logic [2:0] CLS_DIR     = 3'd3;
  localparam logic [2:0] CLS_DIG_HI  = 3'd4;
  localparam logic [2:0] CLS_ANALOG  = 3'd5;

  // Bit masks
  localparam logic [7:0] MASK_DIG1_CLS  = 8'hFE;
  localparam logic [7:0] MASK_DIG2_LOW  = 8'h03;
  localparam logic [7:0] MASK_DIG2_HIGH = 8'hFC;
  localparam logic [7:0] MASK_AUX       = 8'h0F;
  localparam logic [7:0] MASK_SAFETY    = 8'h01;
  localparam logic [7:0] STOP_FLAG_MASK = 8'h02;
  localparam logic [7:0] MASK_SAF_PAIR  = 8'h30;
  localparam logic [7:0] PRESENCE_RST   = 8'hFF;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_a;
    logic       load_b;
    logic       eval;
    logic [3:0] idx;
  } dcv_ctl_t;

  // Latched evaluation results
  typedef struct packed {
    logic       dmis;
    logic       amis;
    logic [2:0] cls;
    logic       start;
  } dcv_res_t;

endpackage

### hw/rtl/dcv_if.sv
// Handshake interfaces for the command and telegram channels.
interface dcv_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [3:0] slot;
  logic [7:0] value;
  logic [7:0] local_aux;

  modport source (output valid, op, slot, value, local_aux, input ready);
  modport sink (input valid, op, slot, value, local_aux, output ready);
endinterface

interface dcv_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] telegram_index;
  logic [7:0] telegram_byte;
  logic       digital_mismatch;
  logic       analog_mismatch;
  logic [2:0] command_class;
  logic       start_active;
  logic       last;

  modport source (output valid, telegram_index, telegram_byte, digital_mismatch,
                  analog_mismatch, command_class, start_active, last,
                  input ready);
  modport sink (input valid, telegram_index, telegram_byte, digital_mismatch,
                analog_mismatch, command_class, start_active, last,
                output ready);
endinterface

### hw/rtl/dcv_ctrl.sv
// Controller: accepts transactions and sequences the thirteen telegram bytes.
module dcv_ctrl
  import dcv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  input  logic       out_ready,
  output logic       in_ready,
  output logic       out_valid,
  output dcv_ctl_t   ctl
);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       in_ready_r, in_ready_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;

  assign in_acc = in_valid && in_ready_r;

  // Commands to the datapath
  always_comb begin
    ctl.load_a = in_acc && (in_op == OP_LOAD_A);
    ctl.load_b = in_acc && (in_op == OP_LOAD_B);
    ctl.eval   = in_acc && (in_op == OP_EVAL);
    ctl.idx    = idx_r;
  end

  // Next state
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.eval) begin
          state_nxt     = S_EMIT;
          idx_nxt       = TLG_SAFETY;
          in_ready_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          if (idx_r == TLG_LAST) begin
            state_nxt     = S_IDLE;
            in_ready_nxt  = 1'b1;
            out_valid_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= TLG_SAFETY;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

### hw/rtl/dcv_datapath.sv
// Datapath: channel records, configuration, voting and telegram byte select.
module dcv_datapath
  import dcv_pkg::*;
#(
  parameter int ANALOG_CHANNELS = ANALOG_CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dcv_ctl_t   ctl,
  input  logic [3:0] slot,
  input  logic [7:0] value,
  input  logic [7:0] local_aux,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output logic [7:0] tlg_byte,
  output dcv_res_t   res
);

  logic [7:0] rec_a_r [REC_LEN];
  logic [7:0] rec_b_r [REC_LEN];
  logic [7:0] tol_r, conn_r, tap_low_r, tap_high_r, tap_nom_r;
  logic [7:0] presence_r, presence_nxt;
  logic       first_r;
  dcv_res_t   res_r, res_nxt;

  logic       saf_a, saf_b;
  logic [7:0] safety_byte;
  logic [7:0] dir_hi, dir_lo, dig1, dig2;
  logic [7:0] analog_out_of_tap;
  logic [7:0] analog_mis;
  logic [7:0] ana_val [8];
  logic [3:0] ana_slot;
  logic [3:0] dig_slot;

  // Record loads
  always_ff @(posedge clk) begin
    if (ctl.load_a && (slot < SLOT_LIMIT)) begin
      rec_a_r[slot] <= value;
    end
    if (ctl.load_b && (slot < SLOT_LIMIT)) begin
      rec_b_r[slot] <= value;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r      <= TOLERANCE_RST;
      conn_r     <= CONNECT_RST;
      tap_low_r  <= TAP_LOW_RST;
      tap_high_r <= TAP_HIGH_RST;
      tap_nom_r  <= TAP_NOM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOLERANCE: tol_r      <= cfg_wdata;
        REG_CONNECT:   conn_r     <= cfg_wdata;
        REG_TAP_LOW:   tap_low_r  <= cfg_wdata;
        REG_TAP_HIGH:  tap_high_r <= cfg_wdata;
        REG_TAP_NOM:   tap_nom_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Voted fixed bytes
  always_comb begin
    saf_a = ((rec_a_r[SLOT_SAFETY] & MASK_SAFETY) != 8'h00) ||
            (rec_a_r[SLOT_DIR_HI] != 8'h00) || (rec_a_r[SLOT_DIR_LO] != 8'h00);
    saf_b = ((rec_b_r[SLOT_SAFETY] & MASK_SAFETY) != 8'h00) ||
            (rec_b_r[SLOT_DIR_HI] != 8'h00) || (rec_b_r[SLOT_DIR_LO] != 8'h00);
    safety_byte = {rec_a_r[SLOT_SAFETY][1], rec_b_r[SLOT_SAFETY][1], saf_a, saf_b, 4'h0};
    dir_hi = rec_a_r[SLOT_DIR_HI] & rec_b_r[SLOT_DIR_HI];
    dir_lo = rec_a_r[SLOT_DIR_LO] & rec_b_r[SLOT_DIR_LO];
    dig1   = rec_a_r[SLOT_DIG1] & rec_b_r[SLOT_DIG1];
    dig2   = rec_a_r[SLOT_DIG2] & rec_b_r[SLOT_DIG2];
  end

  // Joystick presence (latched on first evaluation) and substituted values;
  // presence bit j belongs to analog slot j
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      presence_nxt[j] = first_r ? (rec_b_r[j] >= conn_r) : presence_r[j];
      ana_val[j]      = presence_nxt[j] ? rec_b_r[j] : tap_nom_r;
      analog_out_of_tap[j] = (ana_val[j] < tap_low_r) || (ana_val[j] > tap_high_r);
    end
  end

  // Per-channel tolerance window, 9-bit so a +- t never wraps
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (i < ANALOG_CHANNELS) begin
        analog_mis[i] = (({1'b0, rec_b_r[i]} + {1'b0, tol_r}) < {1'b0, rec_a_r[i]}) ||
                        ({1'b0, rec_b_r[i]} > ({1'b0, rec_a_r[i]} + {1'b0, tol_r}));
      end else begin
        analog_mis[i] = 1'b0;
      end
    end
  end

  // Flags and priority class
  always_comb begin
    res_nxt.dmis = (rec_a_r[SLOT_DIR_HI] != rec_b_r[SLOT_DIR_HI]) ||
                   (rec_a_r[SLOT_DIR_LO] != rec_b_r[SLOT_DIR_LO]) ||
                   (rec_a_r[SLOT_DIG1] != rec_b_r[SLOT_DIG1]) ||
                   (rec_a_r[SLOT_DIG2] != rec_b_r[SLOT_DIG2]);
    res_nxt.amis  = |analog_mis;
    res_nxt.start = dig1[0];
    priority if (((safety_byte & MASK_SAF_PAIR) != 8'h00) &&
                 (((rec_a_r[SLOT_SAFETY] & MASK_SAFETY) != 8'h00) ||
                  ((rec_b_r[SLOT_SAFETY] & MASK_SAFETY) != 8'h00))) begin
      res_nxt.cls = CLS_SAFETY;
    end else if (((dig1 & MASK_DIG1_CLS) != 8'h00) ||
                 ((dig2 & MASK_DIG2_LOW) != 8'h00)) begin
      res_nxt.cls = CLS_DIG_LOW;
    end else if ((dir_lo != 8'h00) || (dir_hi != 8'h00)) begin
      res_nxt.cls = CLS_DIR;
    end else if (((local_aux & MASK_AUX) != 8'h00) ||
                 ((dig2 & MASK_DIG2_HIGH) != 8'h00)) begin
      res_nxt.cls = CLS_DIG_HI;
    end else if (|analog_out_of_tap) begin
      res_nxt.cls = CLS_ANALOG;
    end else begin
      res_nxt.cls = CLS_OFF;
    end
  end

  // Evaluation state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presence_r <= PRESENCE_RST;
      first_r    <= 1'b1;
    end else if (ctl.eval) begin
      presence_r <= presence_nxt;
      first_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      res_r <= res_nxt;
    end
  end

  // Telegram byte select; analog index 5..12 maps to slot 7..0
  assign ana_slot = TLG_LAST - ctl.idx;
  assign dig_slot = ctl.idx + SLOT_SAFETY;

  always_comb begin
    priority if (ctl.idx == TLG_SAFETY) begin
      tlg_byte = safety_byte;
    end else if (ctl.idx <= TLG_LAST_DIG) begin
      tlg_byte = rec_a_r[dig_slot] & rec_b_r[dig_slot];
    end else begin
      tlg_byte = presence_r[ana_slot[2:0]] ? rec_b_r[ana_slot] : tap_nom_r;
    end
  end

  assign res = res_r;

endmodule

### hw/rtl/dual_channel_command_voter.sv
// Top level of the dual-channel command voter.
// Load transactions (op 0 channel A, op 1 channel B) store one record byte;
// slots 13 to 15 and op 3 are accepted and ignored. An evaluate transaction
// (op 2) is voted in the cycle it is accepted and then yields thirteen
// telegram transactions, index 0 to 12, one per cycle while out_tlg.ready is
// high; last marks index 12. The input stays not ready from the evaluate
// until the last telegram byte is taken. Joystick presence is latched from
// channel B on the first evaluate after reset. Configuration writes via
// cfg_we/cfg_index/cfg_wdata must be made while the block is idle.
module dual_channel_command_voter
  import dcv_pkg::*;
#(
  parameter int ANALOG_CHANNELS = ANALOG_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dcv_in_if.sink      in_cmd,
  dcv_out_if.source   out_tlg,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  dcv_ctl_t   ctl;
  dcv_res_t   res;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] tlg_byte;

  dcv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_cmd.valid),
    .in_op     (in_cmd.op),
    .out_ready (out_tlg.ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  dcv_datapath #(
    .ANALOG_CHANNELS (ANALOG_CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .slot      (in_cmd.slot),
    .value     (in_cmd.value),
    .local_aux (in_cmd.local_aux),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .tlg_byte  (tlg_byte),
    .res       (res)
  );

  // Channel outputs
  assign in_cmd.ready             = in_ready;
  assign out_tlg.valid            = out_valid;
  assign out_tlg.telegram_index   = ctl.idx;
  assign out_tlg.telegram_byte    = tlg_byte;
  assign out_tlg.digital_mismatch = res.dmis;
  assign out_tlg.analog_mismatch  = res.amis;
  assign out_tlg.command_class    = res.cls;
  assign out_tlg.start_active     = res.start;
  assign out_tlg.last             = (ctl.idx == TLG_LAST);

  // Input and output sides are never open together
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_cmd.ready && out_tlg.valid))
    else $error("input ready while telegram pending");

  // An evaluate starts the telegram at the safety byte
  a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_cmd.valid && in_cmd.ready && (in_cmd.op == OP_EVAL)) |=>
      (out_tlg.valid && (out_tlg.telegram_index == TLG_SAFETY)))
    else $error("evaluate did not start telegram at index 0");

  // Taking the last byte reopens the input
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tlg.valid && out_tlg.ready && out_tlg.last) |=>
      (in_cmd.ready && !out_tlg.valid))
    else $error("input not reopened after last telegram byte");

  // Index steps by one per taken byte
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tlg.valid && out_tlg.ready && !out_tlg.last) |=>
      (out_tlg.valid &&
       (out_tlg.telegram_index == ($past(out_tlg.telegram_index) + 4'd1))))
    else $error("telegram index skipped");

endmodule
